### hdl/kmsne_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kmsne_pkg;

  // Scan geometry defaults
  localparam int DefaultRowCount    = 4;
  localparam int DefaultColumnCount = 4;

  // Row sample width carried on the input port
  localparam int RowBitsW = 4;

  // Configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 7;

  localparam logic [CfgIdxW-1:0] CfgBaseNote      = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPressVelocity = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgChannelNumber = 2'd2;

  // Configuration reset values
  localparam logic [6:0] BaseNoteReset = 7'h15;
  localparam logic [6:0] VelocityReset = 7'd127;
  localparam logic [3:0] ChannelReset  = 4'h0;

  // One sampled column waiting to be reported
  typedef struct packed {
    logic                valid;
    logic [RowBitsW-1:0] rows;
    logic [RowBitsW-1:0] pend;
    logic [1:0]          col;
    logic [6:0]          note_base;
    logic [3:0]          drive;
  } item_t;

  // Emitter feedback to the scan stage
  typedef struct packed {
    logic                fire;
    logic                done;
    logic [RowBitsW-1:0] pend_left;
  } emit_fb_t;

  // One result item
  typedef struct packed {
    logic       event_valid;
    logic [1:0] key_row;
    logic [1:0] key_column;
    logic       pressed;
    logic [6:0] pitch;
    logic [6:0] velocity;
    logic [3:0] channel;
    logic [3:0] column_drive;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

### hdl/key_matrix_scan_note_events_core.sv
`timescale 1ns / 1ps
`default_nettype none
// The sample is registered in the scan stage, then each of its results in the result register.
// Results leave the result register one per cycle while out_stall_i is low; a sample gives max(1,
// changed rows) results, up to 4, from the single result register emitting one event per cycle.
// Reset: column 0 next to scan, stored row levels all released, base note 21, velocity 127,
// channel 0, no result pending.

module key_matrix_scan_note_events_core #(
  parameter int ROW_COUNT    = kmsne_pkg::DefaultRowCount,
  parameter int COLUMN_COUNT = kmsne_pkg::DefaultColumnCount
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [kmsne_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [kmsne_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [kmsne_pkg::RowBitsW-1:0] row_bits_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                event_valid_o,
  output logic [1:0]                          key_row_o,
  output logic [1:0]                          key_column_o,
  output logic                                pressed_o,
  output logic [6:0]                          pitch_o,
  output logic [6:0]                          velocity_o,
  output logic [3:0]                          channel_o,
  output logic [3:0]                          column_drive_o,
  output logic                                last_o
);

  logic [6:0]          base_note_q;
  logic [6:0]          press_velocity_q;
  logic [3:0]          channel_number_q;
  kmsne_pkg::item_t    item;
  kmsne_pkg::emit_fb_t fb;
  kmsne_pkg::result_t  res;

  // Decode configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_note_q      <= kmsne_pkg::BaseNoteReset;
      press_velocity_q <= kmsne_pkg::VelocityReset;
      channel_number_q <= kmsne_pkg::ChannelReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        kmsne_pkg::CfgBaseNote:      base_note_q      <= cfg_data_i[6:0];
        kmsne_pkg::CfgPressVelocity: press_velocity_q <= cfg_data_i[6:0];
        kmsne_pkg::CfgChannelNumber: channel_number_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  kmsne_scan #(
    .ROW_COUNT    (ROW_COUNT),
    .COLUMN_COUNT (COLUMN_COUNT)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .row_bits_i  (row_bits_i),
    .base_note_i (base_note_q),
    .fb_i        (fb),
    .item_o      (item)
  );

  kmsne_emit u_emit (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_i           (item),
    .press_velocity_i (press_velocity_q),
    .channel_i        (channel_number_q),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .res_o            (res),
    .fb_o             (fb)
  );

  // Break the result out onto its ports
  assign event_valid_o  = res.event_valid;
  assign key_row_o      = res.key_row;
  assign key_column_o   = res.key_column;
  assign pressed_o      = res.pressed;
  assign pitch_o        = res.pitch;
  assign velocity_o     = res.velocity;
  assign channel_o      = res.channel;
  assign column_drive_o = res.column_drive;
  assign last_o         = res.last;

endmodule

`default_nettype wire

### hdl/kmsne_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module kmsne_scan #(
  parameter int ROW_COUNT    = kmsne_pkg::DefaultRowCount,
  parameter int COLUMN_COUNT = kmsne_pkg::DefaultColumnCount
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [kmsne_pkg::RowBitsW-1:0] row_bits_i,
  input  wire logic [6:0]                    base_note_i,
  input  wire kmsne_pkg::emit_fb_t           fb_i,
  output kmsne_pkg::item_t                   item_o
);

  localparam int ColW     = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
  localparam int RowsUsed = (ROW_COUNT > kmsne_pkg::RowBitsW) ? kmsne_pkg::RowBitsW : ROW_COUNT;
  localparam logic [kmsne_pkg::RowBitsW-1:0] RowMask =
    kmsne_pkg::RowBitsW'((1 << RowsUsed) - 1);
  localparam logic [ColW-1:0] LastCol = ColW'(COLUMN_COUNT - 1);

  logic [ColW-1:0]                 col_q, col_d;
  logic [kmsne_pkg::RowBitsW-1:0]  prev_q [COLUMN_COUNT];
  kmsne_pkg::item_t                item_q, item_d;
  logic                            accept;
  logic [kmsne_pkg::RowBitsW-1:0]  rows;
  logic [kmsne_pkg::RowBitsW-1:0]  changed;
  logic [ColW-1:0]                 col_next;

  // Take a new sample once the held one is finished
  assign in_stall_o = item_q.valid & ~fb_i.done;
  assign accept     = in_valid_i & ~in_stall_o;

  // Compare against the stored levels of this column
  assign rows     = row_bits_i & RowMask;
  assign changed  = rows ^ prev_q[col_q];
  assign col_next = (col_q == LastCol) ? '0 : col_q + 1'b1;
  assign col_d    = accept ? col_next : col_q;

  // Load, drain and release the held sample
  always_comb begin
    item_d = item_q;
    if (fb_i.fire) begin
      item_d.pend = fb_i.pend_left;
    end
    if (fb_i.done) begin
      item_d.valid = 1'b0;
    end
    if (accept) begin
      item_d.valid     = 1'b1;
      item_d.rows      = rows;
      item_d.pend      = changed;
      item_d.col       = 2'(col_q);
      item_d.note_base = base_note_i + 7'(ROW_COUNT * int'(col_q));
      item_d.drive     = 4'b0001 << col_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      item_q <= '0;
      for (int i = 0; i < COLUMN_COUNT; i++) begin
        prev_q[i] <= '0;
      end
    end else begin
      col_q  <= col_d;
      item_q <= item_d;
      if (accept) begin
        prev_q[col_q] <= rows;
      end
    end
  end

  assign item_o = item_q;

endmodule

`default_nettype wire

### hdl/kmsne_emit.sv
`timescale 1ns / 1ps
`default_nettype none

module kmsne_emit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire kmsne_pkg::item_t   item_i,
  input  wire logic [6:0]         press_velocity_i,
  input  wire logic [3:0]         channel_i,
  input  wire logic               out_stall_i,
  output logic                    out_valid_o,
  output kmsne_pkg::result_t      res_o,
  output kmsne_pkg::emit_fb_t     fb_o
);

  logic                           out_valid_q, out_valid_d;
  kmsne_pkg::result_t             res_q, res_d;
  logic [1:0]                     sel_row;
  logic [kmsne_pkg::RowBitsW-1:0] sel_oh;
  logic [kmsne_pkg::RowBitsW-1:0] pend_left;
  logic                           found;
  logic                           empty;
  logic                           pressed;
  logic                           can_load;
  logic                           fire;

  // Pick the lowest changed row still pending
  always_comb begin
    sel_row = '0;
    sel_oh  = '0;
    found   = 1'b0;
    for (int r = 0; r < kmsne_pkg::RowBitsW; r++) begin
      if (item_i.pend[r] && !found) begin
        sel_row   = 2'(r);
        sel_oh[r] = 1'b1;
        found     = 1'b1;
      end
    end
  end

  assign empty     = (item_i.pend == '0);
  assign pend_left = item_i.pend & ~sel_oh;
  assign pressed   = |(item_i.rows & sel_oh);

  // Advance when the result register is free or being drained
  assign can_load = ~out_valid_q | ~out_stall_i;
  assign fire     = item_i.valid & can_load;

  assign fb_o.fire      = fire;
  assign fb_o.done      = fire & (pend_left == '0);
  assign fb_o.pend_left = pend_left;

  // Build one result
  always_comb begin
    res_d.event_valid  = ~empty;
    res_d.key_row      = sel_row;
    res_d.key_column   = item_i.col;
    res_d.pressed      = pressed;
    res_d.pitch        = empty ? 7'd0 : item_i.note_base + 7'(sel_row);
    res_d.velocity     = pressed ? press_velocity_i : 7'd0;
    res_d.channel      = channel_i;
    res_d.column_drive = item_i.drive;
    res_d.last         = (pend_left == '0);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result until its transfer
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

### test/note_event_checker.sv
`timescale 1ns / 1ps

module note_event_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [kmsne_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [kmsne_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [kmsne_pkg::RowBitsW-1:0] row_bits_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  kmsne_pkg::result_t             result_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             checked_o
);

  // Shadow of the voicing registers
  logic [6:0] base_note_q;
  logic [6:0] velocity_q;
  logic [3:0] channel_q;

  // Shadow of the scan state
  logic [1:0] scan_col_q;
  logic [3:0] held_rows_q [4];

  kmsne_pkg::result_t expected_events [$];
  int                 fail_count;
  int                 checked_count;

  assign fail_count_o = fail_count;
  assign pending_o    = expected_events.size();
  assign checked_o    = checked_count;

  // Work out the note events caused by one column sample and queue them
  function automatic void predict_scan(input logic [3:0] rows);
    logic [1:0]         col;
    logic [1:0]         nxt;
    logic [3:0]         changed;
    logic [3:0]         drive;
    kmsne_pkg::result_t ev;
    int                 n;
    col     = scan_col_q;
    nxt     = col + 2'd1;
    drive   = 4'b0001 << nxt;
    changed = rows ^ held_rows_q[col];
    n       = 0;
    for (int r = 0; r < 4; r++) begin
      if (changed[r]) begin
        ev.event_valid  = 1'b1;
        ev.key_row      = r[1:0];
        ev.key_column   = col;
        ev.pressed      = rows[r];
        ev.pitch        = base_note_q + {3'd0, col, 2'd0} + 7'(r);
        ev.velocity     = rows[r] ? velocity_q : 7'd0;
        ev.channel      = channel_q;
        ev.column_drive = drive;
        ev.last         = 1'b0;
        expected_events.push_back(ev);
        n++;
      end
    end
    // No change: one empty result still reports the column
    if (n == 0) begin
      ev              = '0;
      ev.key_column   = col;
      ev.channel      = channel_q;
      ev.column_drive = drive;
      expected_events.push_back(ev);
    end
    expected_events[expected_events.size() - 1].last = 1'b1;
    held_rows_q[col] = rows;
    scan_col_q       = nxt;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Watch configuration writes, input transfers and result transfers
  always @(posedge clk_i or negedge rst_ni) begin : watch
    kmsne_pkg::result_t want;
    if (!rst_ni) begin
      base_note_q = kmsne_pkg::BaseNoteReset;
      velocity_q  = kmsne_pkg::VelocityReset;
      channel_q   = kmsne_pkg::ChannelReset;
      scan_col_q  = 2'd0;
      for (int c = 0; c < 4; c++) held_rows_q[c] = 4'd0;
      expected_events.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_events.size() == 0) begin
          $error("unexpected result transfer with no event pending");
          fail_count++;
        end else begin
          want = expected_events.pop_front();
          check_field("event_valid", want.event_valid, result_i.event_valid);
          check_field("key_row", want.key_row, result_i.key_row);
          check_field("key_column", want.key_column, result_i.key_column);
          check_field("pressed", want.pressed, result_i.pressed);
          check_field("pitch", want.pitch, result_i.pitch);
          check_field("velocity", want.velocity, result_i.velocity);
          check_field("channel", want.channel, result_i.channel);
          check_field("column_drive", want.column_drive, result_i.column_drive);
          check_field("last", want.last, result_i.last);
          checked_count++;
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          kmsne_pkg::CfgBaseNote:      base_note_q = cfg_data_i;
          kmsne_pkg::CfgPressVelocity: velocity_q  = cfg_data_i;
          kmsne_pkg::CfgChannelNumber: channel_q   = cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_scan(row_bits_i);
    end
  end

  initial begin
    fail_count    = 0;
    checked_count = 0;
  end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  logic                           clk         = 1'b0;
  logic                           rst_n       = 1'b0;
  logic                           cfg_we      = 1'b0;
  logic [kmsne_pkg::CfgIdxW-1:0]  cfg_index   = kmsne_pkg::CfgBaseNote;
  logic [kmsne_pkg::CfgDataW-1:0] cfg_data    = '0;
  logic                           in_valid    = 1'b0;
  logic [kmsne_pkg::RowBitsW-1:0] row_bits    = '0;
  logic                           out_stall   = 1'b0;
  logic                           in_stall;
  logic                           out_valid;
  logic                           event_valid;
  logic [1:0]                     key_row;
  logic [1:0]                     key_column;
  logic                           pressed;
  logic [6:0]                     pitch;
  logic [6:0]                     velocity;
  logic [3:0]                     channel;
  logic [3:0]                     column_drive;
  logic                           last;
  kmsne_pkg::result_t             dut_result;

  int          fail_count;
  int          pending;
  int          checked;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          items_sent    = 0;

  // Stimulus-side copy of the key matrix, used to shape well-formed scans
  logic [3:0] key_levels [4] = '{4'd0, 4'd0, 4'd0, 4'd0};
  logic [1:0] scan_col       = 2'd0;

  always #5 clk = ~clk;

  key_matrix_scan_note_events_core i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .row_bits_i     (row_bits),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .event_valid_o  (event_valid),
    .key_row_o      (key_row),
    .key_column_o   (key_column),
    .pressed_o      (pressed),
    .pitch_o        (pitch),
    .velocity_o     (velocity),
    .channel_o      (channel),
    .column_drive_o (column_drive),
    .last_o         (last)
  );

  assign dut_result = {event_valid, key_row, key_column, pressed, pitch, velocity,
                       channel, column_drive, last};

  note_event_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .row_bits_i   (row_bits),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .result_i     (dut_result),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Stall the result side at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Hold off until every predicted event has come out
  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [kmsne_pkg::CfgIdxW-1:0] idx,
                           input logic [kmsne_pkg::CfgDataW-1:0] value);
    in_valid = 1'b0;
    wait_drained();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_voicing(input logic [6:0] base, input logic [6:0] vel,
                             input logic [3:0] chan);
    write_reg(kmsne_pkg::CfgBaseNote, base);
    write_reg(kmsne_pkg::CfgPressVelocity, vel);
    write_reg(kmsne_pkg::CfgChannelNumber, {3'd0, chan});
  endtask

  // Present one column sample and hold it until the transfer
  task automatic send_rows(input logic [3:0] bits);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    row_bits = bits;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    key_levels[scan_col] = bits;
    scan_col++;
    items_sent++;
  endtask

  // Mostly changes to the held levels of the current column, some repeats and some noise
  function automatic logic [3:0] next_rows();
    logic [3:0]  held;
    int unsigned pick;
    held = key_levels[scan_col];
    pick = $urandom_range(99);
    if (pick < 20) return held;
    else if (pick < 55) return held ^ (4'b0001 << $urandom_range(3));
    else if (pick < 80) return held ^ 4'($urandom_range(15));
    else return 4'($urandom_range(15));
  endfunction

  task automatic run_random(input int count, input int unsigned send_pct,
                            input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      // Pause the sender once mid-phase until the block has drained
      if (i == count / 2) begin
        in_valid = 1'b0;
        wait_drained();
      end
      send_rows(next_rows());
    end
    in_valid      = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
  endtask

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    logic [3:0] opening [12];
    logic [3:0] wrapped [8];
    // Columns 0..3 in turn, with no change, full presses, full releases and partial changes
    opening = '{4'b0000, 4'b1111, 4'b0001, 4'b1000,
                4'b1111, 4'b0000, 4'b0001, 4'b0110,
                4'b0101, 4'b1010, 4'b1110, 4'b0110};
    // Runs with the note wrapping past 127 and a zero press velocity
    wrapped = '{4'b0000, 4'b0101, 4'b1111, 4'b1111,
                4'b1111, 4'b0000, 4'b0000, 4'b1001};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed scans, first under the reset voicing
    foreach (opening[i]) send_rows(opening[i]);
    set_voicing(7'd127, 7'd0, 4'd15);
    foreach (wrapped[i]) send_rows(wrapped[i]);

    // Random scans over several voicings and idle patterns
    set_voicing(7'd0, 7'd1, 4'd0);
    run_random(100, 13, 86);
    set_voicing(7'd112, 7'd127, 4'd15);
    run_random(100, 86, 13);
    set_voicing(7'($urandom_range(127)), 7'($urandom_range(127)), 4'($urandom_range(15)));
    run_random(100, 0, 0);

    in_valid = 1'b0;
    wait_drained();
    repeat (10) @(negedge clk);

    $display("Scanned %0d column samples under five register settings,", items_sent);
    $display("with %0d note and empty results checked field by field.", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/kmsne_pkg.sv
hdl/kmsne_scan.sv
hdl/kmsne_emit.sv
hdl/key_matrix_scan_note_events_core.sv
test/note_event_checker.sv
test/testbench.sv
